[rtl/symmetric_fir_mirror_edges_defines.svh]
// Assertion macros of the filter module.
`ifndef SYMMETRIC_FIR_MIRROR_EDGES_DEFINES_SVH
`define SYMMETRIC_FIR_MIRROR_EDGES_DEFINES_SVH
`ifndef SYNTHESIS
`define SFM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SFM_ASSERT_R(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SFM_ASSERT(label, clk, rst, prop, msg)
`define SFM_ASSERT_R(label, clk, prop, msg)
`endif
`endif

[rtl/sfm_pkg.sv]
// Constants, types and the coefficient table of the mirrored-edge FIR.
`default_nettype none
package sfm_pkg;
  // The coefficient table fixes the tap count and the coefficient width.
  localparam int TAPS = 63;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH = 18;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MAC, ST_ROUND, ST_OUT
  } state_t;

  // Q1.17 coefficients of taps 0 to the centre; the rest mirror them.
  function automatic logic signed [24:0] coef(input logic [6:0] t);
    logic signed [24:0] c;
    case (t)
      7'd0: c = -25'sd4;      7'd1: c = -25'sd3;      7'd2: c = 25'sd13;
      7'd3: c = 25'sd19;      7'd4: c = -25'sd23;     7'd5: c = -25'sd57;
      7'd6: c = 25'sd17;      7'd7: c = 25'sd123;     7'd8: c = 25'sd33;
      7'd9: c = -25'sd206;    7'd10: c = -25'sd162;   7'd11: c = 25'sd266;
      7'd12: c = 25'sd397;    7'd13: c = -25'sd229;   7'd14: c = -25'sd729;
      7'd15: c = 25'sd0;      7'd16: c = 25'sd1096;   7'd17: c = 25'sd519;
      7'd18: c = -25'sd1360;  7'd19: c = -25'sd1389;  7'd20: c = 25'sd1308;
      7'd21: c = 25'sd2605;   7'd22: c = -25'sd660;   7'd23: c = -25'sd4068;
      7'd24: c = -25'sd962;   7'd25: c = 25'sd5592;   7'd26: c = 25'sd4211;
      7'd27: c = -25'sd6936;  7'd28: c = -25'sd11172; 7'd29: c = 25'sd7862;
      7'd30: c = 25'sd40764;  7'd31: c = 25'sd57344;
      default: c = 25'sd0;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

[rtl/sfm_mac.sv]
// Digit-serial multiply-accumulate: a pre-added sample pair times a coefficient.
`default_nettype none
module sfm_mac #(
  parameter int SW = sfm_pkg::SAMPLE_WIDTH_DEF,
  parameter int CW = sfm_pkg::COEF_WIDTH,
  parameter int AW = SW + CW + 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 clear,
  input  wire logic                 start,
  input  wire logic signed [SW:0]   pair,
  input  wire logic signed [CW-1:0] cf,
  output logic                      busy,
  output logic signed [AW-1:0]      acc
);
  localparam int STEPS = (CW + 1) / 2;
  localparam int CNW = $clog2(STEPS + 1);
  logic [2*STEPS-1:0] mplier;
  logic [CNW-1:0] cnt;
  logic signed [SW+3:0] part;

  // Two multiplier bits a step; the top digit carries the sign weight.
  always_comb begin
    logic signed [2:0] dg;
    dg = signed'({1'b0, mplier[1:0]});
    if (cnt == CNW'(1)) dg = signed'({mplier[1], mplier[1:0]});
    part = (SW+4)'(pair) * (SW+4)'(dg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNW'(STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - CNW'(1);
    end
    if (clear) begin
      acc <= '0;
    end else if (cnt != '0) begin
      acc <= acc + (AW'(part) <<< (2 * (STEPS - int'(cnt))));
    end
    if (start) begin
      mplier <= (2*STEPS)'(signed'(cf));
    end else if (cnt != '0) begin
      mplier <= mplier >> 2;
    end
  end
  assign busy = (cnt != '0);
endmodule
`default_nettype wire

[rtl/symmetric_fir_mirror_edges.sv]
// Framed 63-tap symmetric low-pass FIR with mirrored edges. Samples enter one item per
// handshake and no new item is taken until every result of the current one has left. The
// 63rd sample of a frame releases outputs 0 to 31, each later sample releases the output 31
// samples back, and the final sample flushes the rest, so a frame of 63 or more samples
// gives as many results; a shorter frame gives one error item. One shared digit-serial MAC
// builds each result from 32 pre-added products; for each product the LOAD state and the
// fetch register start the MAC, which then takes two coefficient bits a step, and after the
// last product the ROUND state registers the rounded result, which OUT holds until m_tready.
// An input item gives up to 63 results and is not finished while m_tready stalls; an item
// with no result is taken in IDLE alone, and an error item passes through ROUND and OUT.
`default_nettype none
`include "symmetric_fir_mirror_edges_defines.svh"
module symmetric_fir_mirror_edges #(
  parameter int SAMPLE_WIDTH = sfm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata, // sample_in
  input  wire logic s_tlast,                               // frame_last
  output logic      m_tvalid,
  input  wire logic m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,      // filtered
  output logic [1:0] m_tuser,                             // frame_done, frame_error
  output logic       m_tlast                              // run_last
);
  localparam int TAPS = sfm_pkg::TAPS;
  localparam int COEF_WIDTH = sfm_pkg::COEF_WIDTH;
  localparam int HALF = (TAPS - 1) / 2;
  localparam int IW = $clog2(TAPS);
  localparam int CNTW = $clog2(TAPS + 1);
  localparam int AW = SAMPLE_WIDTH + COEF_WIDTH + 8;
  localparam int DW = ((SAMPLE_WIDTH+7)/8)*8;

  sfm_pkg::state_t state, state_next;
  logic [SAMPLE_WIDTH-1:0] win [TAPS];
  logic [IW-1:0] wptr;
  logic [CNTW-1:0] fill;
  logic last_q, lo_q, hi_q;
  logic [IW:0] c, stop;
  logic [IW:0] t;
  logic signed [SAMPLE_WIDTH:0] pair;
  logic signed [COEF_WIDTH-1:0] cf;
  logic mac_busy, mac_start, mac_clear;
  logic signed [AW-1:0] acc;
  logic err_q;

  function automatic logic [IW-1:0] mpos(input logic signed [IW+2:0] j,
                                         input logic lo, input logic hi);
    logic signed [IW+2:0] k;
    k = j;
    if (k < 0) k = lo ? -k : '0;
    if (k > TAPS - 1) k = hi ? (IW+3)'(2*(TAPS-1)) - k : (IW+3)'(TAPS - 1);
    if (k < 0) k = '0;
    if (k > TAPS - 1) k = (IW+3)'(TAPS - 1);
    return IW'(k);
  endfunction

  // Window position to storage slot; the oldest sample sits at the write pointer.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base, input logic [IW-1:0] i);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, i};
    if (s >= (IW+1)'(TAPS)) s = s - (IW+1)'(TAPS);
    return IW'(s);
  endfunction

  // Pre-add of mirrored taps; the centre tap pairs with zero.
  always_ff @(posedge clk) begin
    logic signed [IW+2:0] d;
    d = (IW+3)'(HALF) - signed'({2'b0, t});
    if (t == (IW+1)'(HALF)) begin
      pair <= (SAMPLE_WIDTH+1)'(signed'(win[phys(wptr, IW'(c))]));
    end else begin
      pair <= (SAMPLE_WIDTH+1)'(signed'(win[phys(wptr,
                mpos(signed'({2'b0, c}) - d, lo_q, hi_q))]))
            + (SAMPLE_WIDTH+1)'(signed'(win[phys(wptr,
                mpos(signed'({2'b0, c}) + d, lo_q, hi_q))]));
    end
    cf <= COEF_WIDTH'(sfm_pkg::coef(t));
  end

  sfm_mac #(.SW(SAMPLE_WIDTH), .CW(COEF_WIDTH), .AW(AW)) u_mac (
    .clk, .rst, .clear(mac_clear), .start(mac_start), .pair, .cf,
    .busy(mac_busy), .acc);

  // Rounding and saturation of the finished sum.
  logic signed [AW-1:0] rsum;
  logic signed [SAMPLE_WIDTH-1:0] rsat;
  always_comb begin
    rsum = (acc + (AW'(1) <<< (COEF_WIDTH - 2))) >>> (COEF_WIDTH - 1);
    if (rsum > AW'((1 <<< (SAMPLE_WIDTH-1)) - 1)) rsat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    else if (rsum < -AW'(1 <<< (SAMPLE_WIDTH-1))) rsat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    else rsat = SAMPLE_WIDTH'(rsum);
  end

  logic fetch;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfm_pkg::ST_IDLE;
      fill <= '0;
      wptr <= '0;
      m_tvalid <= 1'b0;
      fetch <= 1'b0;
    end else begin
      state <= state_next;
      fetch <= (state == sfm_pkg::ST_LOAD);
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        sfm_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            win[wptr] <= s_tdata[SAMPLE_WIDTH-1:0];
            wptr <= (wptr == IW'(TAPS - 1)) ? '0 : wptr + IW'(1);
            last_q <= s_tlast;
            lo_q <= (fill != CNTW'(TAPS));
            hi_q <= s_tlast;
            c <= (fill == CNTW'(TAPS)) ? (IW+1)'(HALF) : '0;
            stop <= s_tlast ? (IW+1)'(TAPS - 1) : (IW+1)'(HALF);
            err_q <= (fill < CNTW'(TAPS - 1)) && s_tlast;
            if (s_tlast) fill <= '0;
            else if (fill != CNTW'(TAPS)) fill <= fill + CNTW'(1);
            t <= '0;
          end
        end
        sfm_pkg::ST_MAC: begin
          if (!mac_busy && !fetch) begin
            if (t == (IW+1)'(HALF)) begin
            end else begin
              t <= t + (IW+1)'(1);
            end
          end
        end
        sfm_pkg::ST_ROUND: begin
          m_tvalid <= 1'b1;
          m_tdata <= err_q ? '0 : DW'(rsat);
          m_tuser <= {err_q ? 1'b1 : (last_q && c == stop), err_q};
          m_tlast <= err_q || (c == stop);
        end
        sfm_pkg::ST_OUT: begin
          if (m_tready) begin
            c <= c + (IW+1)'(1);
            t <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Next state.
  logic full_now;
  assign full_now = s_tlast ? (fill == CNTW'(TAPS - 1)) || (fill == CNTW'(TAPS))
                            : (fill >= CNTW'(TAPS - 1));
  always_comb begin
    state_next = state;
    case (state)
      sfm_pkg::ST_IDLE:
        if (s_tvalid) begin
          if (full_now) state_next = sfm_pkg::ST_LOAD;
          else if (s_tlast) state_next = sfm_pkg::ST_ROUND;
        end
      sfm_pkg::ST_LOAD: state_next = sfm_pkg::ST_MAC;
      sfm_pkg::ST_MAC:
        if (!mac_busy && !fetch && t == (IW+1)'(HALF)) state_next = sfm_pkg::ST_ROUND;
        else if (!mac_busy && !fetch) state_next = sfm_pkg::ST_LOAD;
      sfm_pkg::ST_ROUND: state_next = sfm_pkg::ST_OUT;
      sfm_pkg::ST_OUT:
        if (m_tready) state_next = (err_q || c == stop) ? sfm_pkg::ST_IDLE
                                                       : sfm_pkg::ST_LOAD;
      default: state_next = sfm_pkg::ST_IDLE;
    endcase
  end

  // Handshake and MAC control outputs.
  always_comb begin
    s_tready = (state == sfm_pkg::ST_IDLE);
    mac_start = fetch;
    mac_clear = (state == sfm_pkg::ST_IDLE) ||
                (state == sfm_pkg::ST_OUT && m_tready);
  end

  `SFM_ASSERT(a_no_take_busy, clk, rst, !(s_tready && m_tvalid && state != sfm_pkg::ST_IDLE), "ready while working")
  `SFM_ASSERT(a_err_done, clk, rst, (m_tvalid && m_tuser[0]) |-> (m_tuser[1] && m_tlast), "error item not final")
  `SFM_ASSERT(a_done_last, clk, rst, (m_tvalid && m_tuser[1]) |-> m_tlast, "done without run end")
  `SFM_ASSERT_R(a_fill_range, clk, rst || (fill <= CNTW'(TAPS)), "fill count overflow")
endmodule
`default_nettype wire

[tb/symmetric_fir_mirror_edges_tb.sv]
// Self-checking testbench of the framed 63-tap mirrored-edge low-pass filter.
`default_nettype none
module symmetric_fir_mirror_edges_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS = 63;
  localparam int HALF = (TAPS - 1) / 2;
  localparam int SW = 16;
  localparam int CW = 18;

  typedef struct packed {
    logic signed [SW-1:0] filtered;
    logic frame_error;
    logic frame_done;
    logic run_last;
  } fir_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  symmetric_fir_mirror_edges u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: sliding window of samples and the frame fill count.
  logic signed [SW-1:0] win [TAPS];
  int fill;
  fir_out_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Low-pass coefficients of taps 0 to the centre, Q1.17.
  function automatic longint tap_coef(int t);
    int c [HALF+1] = '{-4, -3, 13, 19, -23, -57, 17, 123,
      33, -206, -162, 266, 397, -229, -729, 0,
      1096, 519, -1360, -1389, 1308, 2605, -660, -4068,
      -962, 5592, 4211, -6936, -11172, 7862, 40764, 57344};
    return c[t];
  endfunction

  function automatic int reflect(int j, bit lo, bit hi);
    if (j < 0) j = lo ? -j : 0;
    if (j > TAPS - 1) j = hi ? 2 * (TAPS - 1) - j : TAPS - 1;
    if (j < 0) j = 0;
    if (j > TAPS - 1) j = TAPS - 1;
    return j;
  endfunction

  function automatic logic signed [SW-1:0] fir_point(int c, bit lo, bit hi);
    longint acc;
    longint q;
    acc = tap_coef(HALF) * longint'(win[c]);
    for (int t = 0; t < HALF; t++) begin
      acc += tap_coef(t) * (longint'(win[reflect(c - (HALF - t), lo, hi)]) +
                            longint'(win[reflect(c + (HALF - t), lo, hi)]));
    end
    acc += longint'(1) << (CW - 2);
    q = acc >>> (CW - 1);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SW-1:0];
  endfunction

  // Update the window and queue the results one input sample causes.
  task automatic predict_sample(logic signed [SW-1:0] s, bit last);
    bit was_full;
    int first, stop;
    fir_out_t r;
    was_full = fill >= TAPS;
    for (int i = 0; i < TAPS - 1; i++) win[i] = win[i+1];
    win[TAPS-1] = s;
    if (fill < TAPS) fill++;
    if (fill < TAPS) begin
      if (last) begin
        r = '{filtered: '0, frame_error: 1'b1, frame_done: 1'b1, run_last: 1'b1};
        expected_q.push_back(r);
        fill = 0;
      end
      return;
    end
    first = was_full ? HALF : 0;
    stop = last ? TAPS - 1 : HALF;
    for (int c = first; c <= stop; c++) begin
      r.filtered = fir_point(c, !was_full, last);
      r.frame_error = 1'b0;
      r.frame_done = last && (c == stop);
      r.run_last = (c == stop);
      expected_q.push_back(r);
    end
    if (last) fill = 0;
  endtask

  // Send one item, idling first at the current rate.
  task automatic send_sample(logic signed [SW-1:0] s, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    predict_sample(s, last);
    s_tvalid <= 1'b1;
    s_tdata <= s;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_frame(int len, int kind);
    logic signed [SW-1:0] s;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: s = SW'($urandom);
        1: s = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
        2: s = (i % 2 != 0) ? 16'sh7fff : 16'sh8000;
        default: s = SW'(int'($urandom_range(200)) - 100);
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Receiver: random stalls, compare each accepted result.
  always @(posedge clk) begin
    fir_out_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{filtered: m_tdata, frame_error: m_tuser[0], frame_done: m_tuser[1],
                run_last: m_tlast};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_directed();
    send_frame(1, 0);
    send_frame(62, 0);
    send_frame(63, 1);
    send_frame(64, 2);
    wait_drained();
  endtask

  task automatic test_random_frames(int idle, int stall, int frames);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int f = 0; f < frames; f++) begin
      if ($urandom_range(5) == 0) send_frame($urandom_range(1, 62), 0);
      else send_frame($urandom_range(63, 80), $urandom_range(3));
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < TAPS; i++) win[i] = '0;
    fill = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_frames(75, 0, 1);
    test_random_frames(0, 75, 1);
    test_random_frames(34, 34, 1);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
